/* rtl/core/rgbkf_pkg.sv */
// Package for the RGB 3x3 kernel filter.
// Holds the pixel and window types, the filter mode codes and the register indexes.
// Depends on nothing.
`default_nettype none

package rgbkf_pkg;

  // Channel and pixel geometry.
  localparam int unsigned CH_W     = 8;
  localparam int unsigned NUM_CH   = 3;
  localparam int unsigned PIX_W    = CH_W * NUM_CH;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned CFG_AW   = 1;

  // Width used for the kernel sums, enough for five times a channel plus sign.
  localparam int unsigned SUM_W    = CH_W + 4;

  // Largest channel value.
  localparam logic [CH_W-1:0] CH_MAX = {CH_W{1'b1}};

  // Reset line length in pixels.
  localparam int unsigned RESET_LINE_LENGTH = 640;

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] REG_LINE_LENGTH = 1'd0;
  localparam logic [CFG_AW-1:0] REG_FILTER_MODE = 1'd1;

  typedef logic [CH_W-1:0] chan_t;

  // One pixel, red in the lowest bits, then green, then blue.
  typedef chan_t [NUM_CH-1:0] pix_t;

  typedef enum logic {
    MODE_BLUR    = 1'b0,
    MODE_SHARPEN = 1'b1
  } filter_mode_e;

  // Three horizontally adjacent pixels.
  typedef struct packed {
    pix_t r;
    pix_t c;
    pix_t l;
  } trip_t;

  // The full 3x3 neighbourhood.
  typedef struct packed {
    trip_t bot;
    trip_t mid;
    trip_t top;
  } window_t;

  // One entry of the line store: the row two above and the row one above.
  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } line_pair_t;

  // Control carried with an item from the input register to the result logic.
  typedef struct packed {
    logic flush;
    logic emit_a;
    logic emit_b;
    logic border;
  } item_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/rgbkf_line_buf.sv */
// Line store for the RGB 3x3 kernel filter: the two previous image rows.
// One write port and one registered read port. Depends on rgbkf_pkg.
`default_nettype none

module rgbkf_line_buf
  import rgbkf_pkg::*;
#(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10
) (
  input  wire logic              clk_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output line_pair_t             rd_data_o,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  line_pair_t             wr_data_i
);

  line_pair_t mem_q [DEPTH];
  line_pair_t rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* rtl/core/rgbkf_kernel.sv */
// Kernel arithmetic of the RGB 3x3 kernel filter: blur or sharpen per channel.
// Purely combinational. Depends on rgbkf_pkg.
`default_nettype none

module rgbkf_kernel
  import rgbkf_pkg::*;
(
  input  filter_mode_e mode_i,
  input  window_t      win_i,
  output pix_t         pix_o
);

  for (genvar k = 0; k < NUM_CH; k++) begin : g_chan
    logic        [SUM_W-1:0] blur_sum;
    logic signed [SUM_W-1:0] tc, ml, mc, mr, bc;
    logic signed [SUM_W-1:0] sharp_sum;
    chan_t                   blur_px;
    chan_t                   sharp_px;

    // Blur: every weighted term is truncated by sixteen before summing.
    assign blur_sum = SUM_W'(win_i.top.l[k] >> 4) + SUM_W'(win_i.top.c[k] >> 3)
                    + SUM_W'(win_i.top.r[k] >> 4) + SUM_W'(win_i.mid.l[k] >> 3)
                    + SUM_W'(win_i.mid.c[k] >> 2) + SUM_W'(win_i.mid.r[k] >> 3)
                    + SUM_W'(win_i.bot.l[k] >> 4) + SUM_W'(win_i.bot.c[k] >> 3)
                    + SUM_W'(win_i.bot.r[k] >> 4);

    assign blur_px = (blur_sum > SUM_W'(CH_MAX)) ? CH_MAX : CH_W'(blur_sum);

    // Sharpen: five times the centre less the four direct neighbours.
    assign tc = $signed(SUM_W'(win_i.top.c[k]));
    assign ml = $signed(SUM_W'(win_i.mid.l[k]));
    assign mc = $signed(SUM_W'(win_i.mid.c[k]));
    assign mr = $signed(SUM_W'(win_i.mid.r[k]));
    assign bc = $signed(SUM_W'(win_i.bot.c[k]));

    assign sharp_sum = (mc <<< 2) + mc - tc - bc - ml - mr;

    // Clamp to the channel range at both ends.
    always_comb begin
      if (sharp_sum < 0) begin
        sharp_px = '0;
      end else if (sharp_sum > $signed(SUM_W'(CH_MAX))) begin
        sharp_px = CH_MAX;
      end else begin
        sharp_px = CH_W'(sharp_sum);
      end
    end

    assign pix_o[k] = (mode_i == MODE_SHARPEN) ? sharp_px : blur_px;
  end

endmodule

`default_nettype wire

/* rtl/core/rgb_3x3_kernel_filter.sv */
// Top level of the RGB 3x3 kernel filter: counters, window, result staging.
// Uses rgbkf_pkg, rgbkf_line_buf and rgbkf_kernel.
`default_nettype none

// Streaming 3x3 blur/sharpen filter for RGB pixels in raster order. Pixels
// enter on the s_axis group (tuser marks the flush items of the draining row
// after a frame) and results leave on the m_axis group, one row and one pixel
// behind the input, with border pixels passed through unchanged. The block
// takes one item per clock while m_axis_tready does not hold the output
// register. An item in the last column of a row (any row but the first) makes
// two results, and since the output register takes one result per clock such
// an item holds the input stage until its second result is loaded. A result
// passes through the item register and the registered line store read, then
// the kernel into the output register. The line store is not cleared after
// reset; what it holds before its first row is written reaches no result.
// Configuration writes are taken at any time but belong to an idle block.
module rgb_3x3_kernel_filter
  import rgbkf_pkg::*;
#(
  parameter int unsigned MAX_LINE = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,

  // Input pixels.
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [PIX_W-1:0]  s_axis_tdata,   // red_in, green_in, blue_in
  input  wire logic              s_axis_tuser,   // flush_item

  // Filtered pixels.
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [PIX_W-1:0]       m_axis_tdata,   // red_out, green_out, blue_out
  output logic                   m_axis_tlast,   // last_of_run
  output logic                   m_axis_tuser,   // end_of_frame

  // Configuration writes.
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_AW-1:0] cfg_addr_i,
  input  wire logic [LEN_W-1:0]  cfg_data_i
);

  localparam int unsigned COL_W      = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam int unsigned RESET_LAST =
    ((RESET_LINE_LENGTH > MAX_LINE) ? MAX_LINE : RESET_LINE_LENGTH) - 1;

  // Row count saturates once it is past the first filtered row.
  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_EDGE  = 2'd1;
  localparam logic [1:0] ROW_INNER = 2'd2;

  // Configuration state.
  logic [COL_W-1:0] last_col_q, last_col_d;
  filter_mode_e     mode_q;
  logic [31:0]      len_req;
  logic [31:0]      len_sat;

  // Input side counters.
  logic [COL_W-1:0] col_q, col_d;
  logic [1:0]       row_q, row_d;
  logic [COL_W-1:0] col_eff;
  logic             in_last;
  logic             accept;

  // Item register.
  logic             s1_valid_q;
  item_ctrl_t       s1_ctrl_q, s1_ctrl_d;
  pix_t             s1_pix_q;
  logic [COL_W-1:0] s1_col_q;
  logic             phase_q;

  // Line store and window.
  line_pair_t       rd_data;
  line_pair_t       wr_data;
  pix_t             win_q [3][2];
  window_t          win;
  pix_t             kern_px;

  // Result staging.
  logic             has_any;
  logic             is_final;
  logic             res_valid;
  pix_t             res_pix;
  logic             res_last;
  logic             res_eof;
  logic             out_free;
  logic             out_load;
  logic             s1_done;

  logic             out_valid_q;
  pix_t             out_pix_q;
  logic             out_last_q;
  logic             out_eof_q;

  // Line length saturated to the supported range, kept as the last column index.
  assign len_req = 32'(cfg_data_i);

  always_comb begin
    if (len_req < 32'd3) begin
      len_sat = 32'd3;
    end else if (len_req > 32'(MAX_LINE)) begin
      len_sat = 32'(MAX_LINE);
    end else begin
      len_sat = len_req;
    end
    last_col_d = COL_W'(len_sat - 32'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= COL_W'(RESET_LAST);
      mode_q     <= MODE_BLUR;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_LINE_LENGTH: last_col_q <= last_col_d;
        REG_FILTER_MODE: mode_q     <= filter_mode_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

  // Column position of the incoming item; past the end counts as the last column.
  assign col_eff = (col_q > last_col_q) ? last_col_q : col_q;
  assign in_last = (col_eff == last_col_q);
  assign accept  = s_axis_tvalid && s_axis_tready;

  always_comb begin
    s1_ctrl_d.flush  = s_axis_tuser;
    s1_ctrl_d.emit_a = (row_q != ROW_FIRST) && (col_eff != '0);
    s1_ctrl_d.emit_b = (row_q != ROW_FIRST) && in_last;
    s1_ctrl_d.border = s_axis_tuser || (row_q == ROW_EDGE) || (col_eff == COL_W'(1));
  end

  // Next column and row after an accepted item.
  always_comb begin
    col_d = col_eff + COL_W'(1);
    row_d = row_q;
    if (in_last) begin
      col_d = '0;
      if (s_axis_tuser) begin
        row_d = ROW_FIRST;
      end else if (row_q != ROW_INNER) begin
        row_d = row_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= ROW_FIRST;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Item register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      phase_q    <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_done) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_done) begin
        phase_q <= 1'b0;
      end else if (out_load) begin
        phase_q <= 1'b1;
      end
    end
  end

  // Item register payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ctrl_q <= s1_ctrl_d;
      s1_pix_q  <= pix_t'(s_axis_tdata);
      s1_col_q  <= col_eff;
    end
  end

  // Line store: read at accept, written with the shifted rows when the item leaves.
  assign wr_data.upper  = rd_data.middle;
  assign wr_data.middle = s1_pix_q;

  rgbkf_line_buf #(
    .DEPTH  (MAX_LINE),
    .ADDR_W (COL_W)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_eff),
    .rd_data_o (rd_data),
    .we_i      (s1_done),
    .wr_addr_i (s1_col_q),
    .wr_data_i (wr_data)
  );

  // Window: two stored columns per row, shifted when the item leaves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= '0;
        win_q[r][1] <= '0;
      end
    end else if (s1_done) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
      end
      win_q[0][1] <= rd_data.upper;
      win_q[1][1] <= rd_data.middle;
      win_q[2][1] <= s1_pix_q;
    end
  end

  assign win.top.l = win_q[0][0];
  assign win.top.c = win_q[0][1];
  assign win.top.r = rd_data.upper;
  assign win.mid.l = win_q[1][0];
  assign win.mid.c = win_q[1][1];
  assign win.mid.r = rd_data.middle;
  assign win.bot.l = win_q[2][0];
  assign win.bot.c = win_q[2][1];
  assign win.bot.r = s1_pix_q;

  rgbkf_kernel u_kernel (
    .mode_i (mode_q),
    .win_i  (win),
    .pix_o  (kern_px)
  );

  // Result selection: the filtered pixel first, then the end-of-row pixel.
  assign has_any   = s1_ctrl_q.emit_a || s1_ctrl_q.emit_b;
  assign is_final  = phase_q || !(s1_ctrl_q.emit_a && s1_ctrl_q.emit_b);
  assign res_valid = s1_valid_q && (phase_q || has_any);

  always_comb begin
    if (!phase_q && s1_ctrl_q.emit_a) begin
      res_pix  = s1_ctrl_q.border ? win_q[1][1] : kern_px;
      res_last = !s1_ctrl_q.emit_b;
      res_eof  = 1'b0;
    end else begin
      res_pix  = rd_data.middle;
      res_last = 1'b1;
      res_eof  = s1_ctrl_q.flush;
    end
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign out_load      = res_valid && out_free;
  assign s1_done       = s1_valid_q && ((!phase_q && !has_any) || (out_load && is_final));
  assign s_axis_tready = !s1_valid_q || s1_done;

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pix_q  <= res_pix;
      out_last_q <= res_last;
      out_eof_q  <= res_eof;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = PIX_W'(out_pix_q);
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_eof_q;

  // The second result of an item only exists for an item in the last column.
  a_phase_needs_two : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (s1_valid_q && s1_ctrl_q.emit_a && s1_ctrl_q.emit_b))
    else $error("second result pending for an item with one result");

  // After an accepted item with no configuration write in the same cycle, the column never lies past the last column.
  a_col_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cfg_we_i) |=> (col_q <= last_col_q))
    else $error("column counter past the last column");

  // End of frame is only ever flagged on the closing result of an item.
  a_eof_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_eof_q) |-> out_last_q)
    else $error("end of frame without last of run");

  // Items of the first row of a frame make no results.
  a_first_row_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (row_q == ROW_FIRST)) |=> !res_valid)
    else $error("result produced for the first row");

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for rgb_3x3_kernel_filter: a table of directed items, then random
// frames under three idling regimes, checked against an in-bench pixel predictor or table values.
// Depends on rgbkf_pkg and the filter RTL only.
module testbench;
  import rgbkf_pkg::*;

  localparam int unsigned LINE_DEPTH  = 1024;
  localparam int unsigned ROW_LIMIT   = 4095;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYC  = 8;

  // One expected filtered pixel with its side-band flags.
  typedef struct packed {
    pix_t px;
    logic tlast;
    logic eof;
  } px_result_t;

  typedef enum logic {ROW_PIX, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {EXP_PREDICTED, EXP_NOTHING, EXP_ONE} row_check_e;

  // One line of the directed stimulus table.
  typedef struct packed {
    row_kind_e         kind;
    logic [CFG_AW-1:0] reg_idx;
    logic [LEN_W-1:0]  reg_val;
    pix_t              px;
    logic              flush;
    row_check_e        verdict;
    pix_t              want;
  } dir_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [PIX_W-1:0]  s_axis_tdata = '0;   // red_in, green_in, blue_in
  logic              s_axis_tuser = 1'b0; // flush_item
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [PIX_W-1:0]  m_axis_tdata;        // red_out, green_out, blue_out
  logic              m_axis_tlast;        // last_of_run
  logic              m_axis_tuser;        // end_of_frame
  logic              cfg_we_i = 1'b0;
  logic [CFG_AW-1:0] cfg_addr_i = '0;
  logic [LEN_W-1:0]  cfg_data_i = '0;

  // Predictor state: line stores, window columns, counters and registers.
  pix_t            upper_row [LINE_DEPTH];
  pix_t            middle_row [LINE_DEPTH];
  pix_t            slide_win [3][2];
  int unsigned     col_cnt = 0;
  int unsigned     row_cnt = 0;
  logic [LEN_W-1:0] len_reg = LEN_W'(RESET_LINE_LENGTH);
  filter_mode_e    mode_reg = MODE_BLUR;

  px_result_t      expected_pixels [$];
  dir_row_t        dir_table [$];
  int unsigned     tx_idle_pct = 13;
  int unsigned     rx_idle_pct = 49;
  int unsigned     rx_stall_left = 0;
  int unsigned     items_sent = 0;
  int unsigned     mismatches = 0;
  int unsigned     cycles = 0;

  rgb_3x3_kernel_filter #(
    .MAX_LINE(LINE_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Free-running clock with a period of 20.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Cycle counter and run limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // One channel through the active kernel; blur truncates each term before summing.
  function automatic chan_t kernel_chan(int t0, int t1, int t2, int m0, int m1, int m2,
                                        int b0, int b1, int b2);
    int s;
    if (mode_reg == MODE_BLUR) begin
      s = t0 / 16 + (2 * t1) / 16 + t2 / 16 + (2 * m0) / 16 + (4 * m1) / 16 +
          (2 * m2) / 16 + b0 / 16 + (2 * b1) / 16 + b2 / 16;
    end else begin
      s = 5 * m1 - t1 - b1 - m0 - m2;
    end
    if (s < 0) s = 0;
    if (s > int'(CH_MAX)) s = int'(CH_MAX);
    return chan_t'(s);
  endfunction

  // Advance the predictor by one accepted item and return the pixels it releases.
  task automatic filter_pixel(input pix_t in_px, input logic flush, output int n,
                              output px_result_t ra, output px_result_t rb);
    int unsigned eff;
    int unsigned col;
    int          ch;
    logic        at_end;
    logic        border;
    pix_t        above2;
    pix_t        above1;
    pix_t        px;
    px_result_t  tail;
    eff = len_reg;
    if (eff < 3) eff = 3;
    if (eff > LINE_DEPTH) eff = LINE_DEPTH;
    col = col_cnt;
    if (col > eff - 1) col = eff - 1;
    at_end = (col == eff - 1);
    above2 = upper_row[col];
    above1 = middle_row[col];
    n = 0;
    ra = '0;
    rb = '0;

    // Centre pixel of the window, filtered unless it sits on the border.
    if (row_cnt != 0 && col >= 1) begin
      border = flush || row_cnt == 1 || col == 1;
      for (ch = 0; ch < NUM_CH; ch++) begin
        if (border) begin
          px[ch] = slide_win[1][1][ch];
        end else begin
          px[ch] = kernel_chan(slide_win[0][0][ch], slide_win[0][1][ch], above2[ch],
                               slide_win[1][0][ch], slide_win[1][1][ch], above1[ch],
                               slide_win[2][0][ch], slide_win[2][1][ch], in_px[ch]);
        end
      end
      ra.px = px;
      ra.tlast = !at_end;
      ra.eof = 1'b0;
      n = 1;
    end

    // The right-hand border pixel of the row above leaves with the last column.
    if (row_cnt != 0 && at_end) begin
      tail.px = above1;
      tail.tlast = 1'b1;
      tail.eof = flush;
      if (n == 0) ra = tail;
      else rb = tail;
      n++;
    end

    slide_win[0][0] = slide_win[0][1];
    slide_win[1][0] = slide_win[1][1];
    slide_win[2][0] = slide_win[2][1];
    slide_win[0][1] = above2;
    slide_win[1][1] = above1;
    slide_win[2][1] = in_px;
    upper_row[col] = above1;
    middle_row[col] = in_px;

    if (at_end) begin
      col_cnt = 0;
      if (flush) row_cnt = 0;
      else if (row_cnt < ROW_LIMIT) row_cnt++;
    end else begin
      col_cnt = col + 1;
    end
  endtask

  // Offer one item, wait for it to be taken, and record what it should produce.
  // Entered and left just after a falling edge.
  task automatic send_pixel(input pix_t px, input logic flush,
                            input row_check_e verdict = EXP_PREDICTED, input pix_t want = '0);
    int         n;
    px_result_t ra;
    px_result_t rb;
    px_result_t typed;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    s_axis_tuser <= flush;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    filter_pixel(px, flush, n, ra, rb);
    case (verdict)
      EXP_PREDICTED: begin
        if (n > 0) expected_pixels.push_back(ra);
        if (n > 1) expected_pixels.push_back(rb);
      end
      EXP_ONE: begin
        typed.px = want;
        typed.tlast = 1'b1;
        typed.eof = 1'b0;
        expected_pixels.push_back(typed);
      end
      default: begin
      end
    endcase
    items_sent++;
    @(negedge clk_i);
  endtask

  // Stop sending until every expected pixel is out, then let the pipeline empty.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  // Single-cycle register write; write enable is low again on return.
  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [LEN_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_LINE_LENGTH) len_reg = val;
    else mode_reg = filter_mode_e'(val[0]);
    @(negedge clk_i);
  endtask

  // Random channel values, weighted towards the extremes.
  function automatic pix_t rand_pixel();
    pix_t p;
    int   ch;
    for (ch = 0; ch < NUM_CH; ch++) begin
      case ($urandom_range(3))
        0: p[ch] = '0;
        1: p[ch] = CH_MAX;
        default: p[ch] = chan_t'($urandom);
      endcase
    end
    return p;
  endfunction

  // One frame: close any open frame, configure, send the rows and usually a flush row.
  task automatic run_frame(input logic [LEN_W-1:0] len_val, input int rows,
                           input int unsigned noise_pct, input int unsigned stall_cycles);
    int unsigned eff;
    int          r;
    int          c;
    logic        mid_pause;
    // A longer line must start on row zero, or it would read columns never stored.
    while (col_cnt != 0 || row_cnt != 0) send_pixel(rand_pixel(), 1'b1);
    wait_drained();
    write_reg(REG_LINE_LENGTH, len_val);
    if ($urandom_range(9) < 7) write_reg(REG_FILTER_MODE, LEN_W'($urandom));
    eff = len_val;
    if (eff < 3) eff = 3;
    if (eff > LINE_DEPTH) eff = LINE_DEPTH;
    if (stall_cycles != 0) rx_stall_left = stall_cycles;
    mid_pause = ($urandom_range(2) == 0);
    for (r = 0; r < rows; r++) begin
      if (r == 1 && mid_pause) wait_drained();
      for (c = 0; c < eff; c++) begin
        send_pixel(rand_pixel(), $urandom_range(99) < noise_pct);
      end
    end
    if ($urandom_range(9) != 0) begin
      for (c = 0; c < eff; c++) send_pixel(rand_pixel(), 1'b1);
    end
  endtask

  function automatic dir_row_t pix_row(pix_t px, logic flush, row_check_e verdict,
                                       pix_t want = '0);
    dir_row_t row;
    row = '0;
    row.kind = ROW_PIX;
    row.px = px;
    row.flush = flush;
    row.verdict = verdict;
    row.want = want;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_AW-1:0] idx, logic [LEN_W-1:0] val);
    dir_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic void cmp_field(string name, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Every item leaving the block is compared with the oldest expectation.
  always @(posedge clk_i) begin
    px_result_t want;
    pix_t       got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_pixels.size() == 0) begin
        $error("result with nothing expected: data %h last %b eof %b",
               m_axis_tdata, m_axis_tlast, m_axis_tuser);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        cmp_field("red_out", want.px[0], got[0]);
        cmp_field("green_out", want.px[1], got[1]);
        cmp_field("blue_out", want.px[2], got[2]);
        cmp_field("last_of_run", CH_W'(want.tlast), CH_W'(m_axis_tlast));
        cmp_field("end_of_frame", CH_W'(want.eof), CH_W'(m_axis_tuser));
      end
    end
  end

  // Stimulus.
  initial begin
    int          regime;
    int unsigned quota_base;
    int          i;
    foreach (upper_row[k]) begin
      upper_row[k] = '0;
      middle_row[k] = '0;
    end
    foreach (slide_win[a, b]) slide_win[a][b] = '0;

    // Pixels are written as 24'hBBGGRR. Rows zero emit nothing; a column-one pixel, or any
    // pixel of row one, passes through the pixel one row up and one column left.
    // First row at the reset length, then a shrink to below the minimum mid-row.
    dir_table.push_back(pix_row(24'h000000, 1'b0, EXP_NOTHING));
    dir_table.push_back(pix_row(24'hFFFFFF, 1'b0, EXP_NOTHING));
    dir_table.push_back(pix_row(24'h00FF00, 1'b0, EXP_NOTHING));
    dir_table.push_back(cfg_row(REG_LINE_LENGTH, 11'd2));
    dir_table.push_back(pix_row(24'hFF00FF, 1'b0, EXP_NOTHING));
    // Row one: pass-through only.
    dir_table.push_back(pix_row(24'hFFFFFF, 1'b0, EXP_NOTHING));
    dir_table.push_back(pix_row(24'h000000, 1'b0, EXP_ONE, 24'h000000));
    dir_table.push_back(pix_row(24'hFFFFFF, 1'b0, EXP_PREDICTED));
    // Row two: first blurred pixel from extreme values.
    dir_table.push_back(pix_row(24'h000000, 1'b0, EXP_NOTHING));
    dir_table.push_back(pix_row(24'hFFFFFF, 1'b0, EXP_ONE, 24'hFFFFFF));
    dir_table.push_back(pix_row(24'h000000, 1'b0, EXP_PREDICTED));
    // Sharpen, with spare data bits set; its sums clamp at the top of the channel range.
    dir_table.push_back(cfg_row(REG_FILTER_MODE, 11'h7FF));
    dir_table.push_back(pix_row(24'hFFFFFF, 1'b0, EXP_NOTHING));
    dir_table.push_back(pix_row(24'h00FF00, 1'b0, EXP_ONE, 24'h000000));
    dir_table.push_back(pix_row(24'hFF00FF, 1'b0, EXP_PREDICTED));
    // A flush in the last column of a normal row forces pass-through and ends the frame.
    dir_table.push_back(pix_row(24'h000000, 1'b0, EXP_NOTHING));
    dir_table.push_back(pix_row(24'hFFFFFF, 1'b0, EXP_ONE, 24'hFFFFFF));
    dir_table.push_back(pix_row(24'h00FF00, 1'b1, EXP_PREDICTED));
    // Flush items in row zero: no output, counters return to zero.
    dir_table.push_back(pix_row(24'h5AA53C, 1'b1, EXP_NOTHING));
    dir_table.push_back(pix_row(24'hC33CA5, 1'b0, EXP_NOTHING));
    dir_table.push_back(pix_row(24'h0F0FF0, 1'b1, EXP_NOTHING));
    // A short frame closed by a proper flush row.
    dir_table.push_back(pix_row(24'h123456, 1'b0, EXP_NOTHING));
    dir_table.push_back(pix_row(24'h807F01, 1'b0, EXP_NOTHING));
    dir_table.push_back(pix_row(24'hFE0180, 1'b0, EXP_NOTHING));
    dir_table.push_back(pix_row(24'h5A5A5A, 1'b1, EXP_NOTHING));
    dir_table.push_back(pix_row(24'hA5A5A5, 1'b1, EXP_ONE, 24'h123456));
    dir_table.push_back(pix_row(24'h3C3CC3, 1'b1, EXP_PREDICTED));

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part.
    for (i = 0; i < dir_table.size(); i++) begin
      if (dir_table[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(dir_table[i].reg_idx, dir_table[i].reg_val);
      end else begin
        send_pixel(dir_table[i].px, dir_table[i].flush, dir_table[i].verdict,
                   dir_table[i].want);
      end
    end

    // Random frames under three idling regimes, each opening with a special frame, the last with two.
    for (regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin
          tx_idle_pct = 13;
          rx_idle_pct = 49;
          run_frame(11'd8, 4, 0, 400);
        end
        1: begin
          tx_idle_pct = 49;
          rx_idle_pct = 13;
          run_frame(11'h7FF, 3, 0, 0);
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          run_frame(11'd6, 3, 0, 300);
          // Enough rows to take the row counter into saturation.
          run_frame(11'd3, 4100, 0, 0);
        end
      endcase
      quota_base = items_sent;
      while (items_sent < quota_base + 550) begin
        case ($urandom_range(9))
          0: run_frame(LEN_W'($urandom_range(0, 2)), $urandom_range(0, 5), 3, 0);
          1: run_frame(LEN_W'($urandom_range(13, 48)), $urandom_range(0, 4), 3, 0);
          default: run_frame(LEN_W'($urandom_range(3, 10)), $urandom_range(0, 6), 3, 0);
        endcase
      end
    end

    wait_drained();
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
